// ===== src/gic_pkg.sv =====
// Shared constants, types and state codes of the game input conditioner.
`timescale 1ns / 1ps
package gic_pkg;

	localparam int          TOUCH_BIT_DEF = 20;
	localparam logic [7:0]  FS_RESET      = 8'd150;
	localparam int          SQRT_STEPS    = 17;
	localparam int          DIV_STEPS     = 15;
	localparam int          CNT_W         = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_CALC1,
		ST_CALC2,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic calc1;
		logic calc2;
		logic div_step;
	} lane_ctl_t;

	typedef struct packed {
		logic [31:0]        pressed;
		logic [31:0]        released;
		logic [8:0]         pos_x;
		logic [7:0]         pos_y;
		logic signed [9:0]  delta_x;
		logic signed [8:0]  delta_y;
		logic signed [9:0]  drag_x;
		logic signed [8:0]  drag_y;
	} touch_res_t;

endpackage

// ===== src/gic_stick_lane.sv =====
// One stick lane: squared length, bit-serial square root and radial scaling divide.
`timescale 1ns / 1ps
module gic_stick_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  gic_pkg::lane_ctl_t  ctl,
	input  logic [7:0]          fs,
	input  logic signed [8:0]   raw_x,
	input  logic signed [8:0]   raw_y,
	output logic signed [15:0]  out_x,
	output logic signed [15:0]  out_y
);

	logic [8:0]  mx_q, my_q;
	logic        nx_q, ny_q, zero_q;
	logic [33:0] nsh_q;
	logic [18:0] rem_q;
	logic [16:0] root_q;
	logic        full_q, mid_q;
	logic [20:0] diff_q;
	logic [24:0] fslq_q;
	logic [43:0] remx_q, remy_q;
	logic [41:0] dsh_q;
	logic [14:0] qx_q, qy_q;

	logic [8:0]  ax, ay;
	logic [17:0] s_in;
	logic [20:0] remn, trial;
	logic [15:0] fs256;
	logic [20:0] lq11;
	logic [27:0] den;
	logic [43:0] numx, numy;
	logic [15:0] ux, uy;

	assign ax    = raw_x[8] ? 9'(-raw_x) : 9'(raw_x);
	assign ay    = raw_y[8] ? 9'(-raw_y) : 9'(raw_y);
	assign s_in  = 18'(ax * ax) + 18'(ay * ay);
	assign remn  = {rem_q, nsh_q[33:32]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fs256 = {fs, 8'd0};
	assign lq11  = ({4'd0, root_q} << 3) + ({4'd0, root_q} << 1) + {4'd0, root_q};
	assign den   = full_q ? {11'd0, root_q}
	                      : ({3'd0, fslq_q} << 3) + ({3'd0, fslq_q} << 1);

	always_comb begin
		if (full_q) begin
			numx = {13'd0, mx_q, 22'd0};
			numy = {13'd0, my_q, 22'd0};
		end else if (mid_q) begin
			numx = {44'(mx_q * diff_q)} << 14;
			numy = {44'(my_q * diff_q)} << 14;
		end else begin
			numx = '0;
			numy = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b1;
			full_q <= 1'b0;
			mid_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				zero_q <= (s_in == '0);
			end
			if (ctl.calc1) begin
				full_q <= ({15'd0, root_q} >= {16'd0, fs256});
				mid_q  <= (lq11 > {5'd0, fs256});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mx_q   <= ax;
			my_q   <= ay;
			nx_q   <= raw_x[8];
			// Y is flipped, so a positive raw Y gives a negative output.
			ny_q   <= ~raw_y[8] && (raw_y != '0);
			nsh_q  <= {s_in, 16'd0};
			rem_q  <= '0;
			root_q <= '0;
		end
		if (ctl.sqrt_step) begin
			nsh_q <= {nsh_q[31:0], 2'b00};
			if (remn >= trial) begin
				rem_q  <= 19'(remn - trial);
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q  <= remn[18:0];
				root_q <= {root_q[15:0], 1'b0};
			end
		end
		if (ctl.calc1) begin
			diff_q <= lq11 - {5'd0, fs256};
			fslq_q <= 25'(fs * root_q);
		end
		if (ctl.calc2) begin
			remx_q <= numx;
			remy_q <= numy;
			dsh_q  <= {den, 14'd0};
			qx_q   <= '0;
			qy_q   <= '0;
		end
		if (ctl.div_step) begin
			dsh_q <= dsh_q >> 1;
			if (remx_q >= {2'b00, dsh_q}) begin
				remx_q <= remx_q - {2'b00, dsh_q};
				qx_q   <= {qx_q[13:0], 1'b1};
			end else begin
				qx_q   <= {qx_q[13:0], 1'b0};
			end
			if (remy_q >= {2'b00, dsh_q}) begin
				remy_q <= remy_q - {2'b00, dsh_q};
				qy_q   <= {qy_q[13:0], 1'b1};
			end else begin
				qy_q   <= {qy_q[13:0], 1'b0};
			end
		end
	end

	assign ux    = {1'b0, qx_q};
	assign uy    = {1'b0, qy_q};
	assign out_x = zero_q ? '0 : (nx_q ? -$signed(ux) : $signed(ux));
	assign out_y = zero_q ? '0 : (ny_q ? -$signed(uy) : $signed(uy));

endmodule

// ===== src/gic_touch.sv =====
// Button edge detection and touch point tracking for one frame.
`timescale 1ns / 1ps
module gic_touch #(
	parameter int TOUCH_BIT = gic_pkg::TOUCH_BIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [31:0]         held,
	input  logic [8:0]          tin_x,
	input  logic [7:0]          tin_y,
	output gic_pkg::touch_res_t res
);

	logic [31:0] prev_q;
	logic [8:0]  cur_x_q, org_x_q;
	logic [7:0]  cur_y_q, org_y_q;
	gic_pkg::touch_res_t res_q;

	logic [31:0] pressed;
	logic [8:0]  nx, lx, ox;
	logic [7:0]  ny, ly, oy;

	always_comb begin
		pressed = held & ~prev_q;
		nx = held[TOUCH_BIT] ? tin_x : cur_x_q;
		ny = held[TOUCH_BIT] ? tin_y : cur_y_q;
		lx = cur_x_q;
		ly = cur_y_q;
		ox = org_x_q;
		oy = org_y_q;
		// A new press restarts the drag and suppresses the delta.
		if (pressed[TOUCH_BIT]) begin
			ox = nx;
			oy = ny;
			lx = nx;
			ly = ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
		end else if (load) begin
			prev_q  <= held;
			cur_x_q <= nx;
			cur_y_q <= ny;
			org_x_q <= ox;
			org_y_q <= oy;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.pressed  <= pressed;
			res_q.released <= prev_q & ~held;
			res_q.pos_x    <= nx;
			res_q.pos_y    <= ny;
			res_q.delta_x  <= $signed({1'b0, nx} - {1'b0, lx});
			res_q.delta_y  <= $signed({1'b0, ny} - {1'b0, ly});
			res_q.drag_x   <= $signed({1'b0, nx} - {1'b0, ox});
			res_q.drag_y   <= $signed({1'b0, ny} - {1'b0, oy});
		end
	end

	assign res = res_q;

endmodule

// ===== src/game_input_conditioner_unit.sv =====
// Top level of the game input conditioner: sequencer, two stick lanes and result register.
// An accepted beat passes through a load, 17 square root steps, the set-up states CALC1 and
// CALC2, 15 steps of the bit-serial divide and a merge into the result register.
// A new beat is taken only once the last one is merged, and it is taken while that result waits.
// Reset (arst_n low) clears button and touch history and sets full scale to 150.
`timescale 1ns / 1ps
module game_input_conditioner_unit #(
	parameter int TOUCH_BIT = gic_pkg::TOUCH_BIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        buttons_held,
	input  logic signed [8:0]  left_x,
	input  logic signed [8:0]  left_y,
	input  logic signed [8:0]  right_x,
	input  logic signed [8:0]  right_y,
	input  logic [8:0]         touch_in_x,
	input  logic [7:0]         touch_in_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        pressed_mask,
	output logic [31:0]        released_mask,
	output logic signed [15:0] left_out_x,
	output logic signed [15:0] left_out_y,
	output logic signed [15:0] right_out_x,
	output logic signed [15:0] right_out_y,
	output logic [8:0]         touch_pos_x,
	output logic [7:0]         touch_pos_y,
	output logic signed [9:0]  touch_delta_x,
	output logic signed [8:0]  touch_delta_y,
	output logic signed [9:0]  drag_x,
	output logic signed [8:0]  drag_y
);

	gic_pkg::state_t     state_q, state_d;
	logic [gic_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]          fs_q;
	logic                out_valid_q;
	gic_pkg::lane_ctl_t  ctl;
	gic_pkg::touch_res_t tres;
	logic                accept, merge;
	logic signed [15:0]  lx, ly, rx, ry;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= gic_pkg::FS_RESET;
		end else if (cfg_valid) begin
			fs_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gic_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ctl      = '0;
		in_stall = 1'b1;
		merge    = 1'b0;
		unique case (state_q)
			gic_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					cnt_d    = gic_pkg::CNT_W'(gic_pkg::SQRT_STEPS - 1);
					state_d  = gic_pkg::ST_SQRT;
				end
			end
			gic_pkg::ST_SQRT: begin
				ctl.sqrt_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = gic_pkg::ST_CALC1;
				end
			end
			gic_pkg::ST_CALC1: begin
				ctl.calc1 = 1'b1;
				state_d   = gic_pkg::ST_CALC2;
			end
			gic_pkg::ST_CALC2: begin
				ctl.calc2 = 1'b1;
				cnt_d     = gic_pkg::CNT_W'(gic_pkg::DIV_STEPS - 1);
				state_d   = gic_pkg::ST_DIV;
			end
			gic_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = gic_pkg::ST_DONE;
				end
			end
			gic_pkg::ST_DONE: begin
				// The result register frees up in the same cycle its beat is taken.
				if (!out_valid_q || !out_stall) begin
					merge   = 1'b1;
					state_d = gic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gic_pkg::ST_IDLE;
			end
		endcase
	end

	gic_stick_lane u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.fs     (fs_q),
		.raw_x  (left_x),
		.raw_y  (left_y),
		.out_x  (lx),
		.out_y  (ly)
	);

	gic_stick_lane u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.fs     (fs_q),
		.raw_x  (right_x),
		.raw_y  (right_y),
		.out_x  (rx),
		.out_y  (ry)
	);

	gic_touch #(
		.TOUCH_BIT (TOUCH_BIT)
	) u_touch (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.held   (buttons_held),
		.tin_x  (touch_in_x),
		.tin_y  (touch_in_y),
		.res    (tres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (merge) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (merge) begin
			pressed_mask  <= tres.pressed;
			released_mask <= tres.released;
			left_out_x    <= lx;
			left_out_y    <= ly;
			right_out_x   <= rx;
			right_out_y   <= ry;
			touch_pos_x   <= tres.pos_x;
			touch_pos_y   <= tres.pos_y;
			touch_delta_x <= tres.delta_x;
			touch_delta_y <= tres.delta_y;
			drag_x        <= tres.drag_x;
			drag_y        <= tres.drag_y;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== bench/tb_game_input_conditioner_unit.sv =====
// Self-checking bench for the game input conditioner: random frames, stick scaling and touch tracking.
`timescale 1ns / 1ps
module tb_game_input_conditioner_unit;

	localparam int TOUCH_BIT  = gic_pkg::TOUCH_BIT_DEF;
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0]       held;
		logic signed [8:0] lx;
		logic signed [8:0] ly;
		logic signed [8:0] rx;
		logic signed [8:0] ry;
		logic [8:0]        tx;
		logic [7:0]        ty;
	} frame_t;

	typedef struct packed {
		logic [31:0]        pressed;
		logic [31:0]        released;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic [8:0]         px;
		logic [7:0]         py;
		logic signed [9:0]  dx;
		logic signed [8:0]  dy;
		logic signed [9:0]  gx;
		logic signed [8:0]  gy;
	} cond_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] buttons_held = '0;
	logic signed [8:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0;
	logic [8:0] touch_in_x = '0;
	logic [7:0] touch_in_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] pressed_mask, released_mask;
	logic signed [15:0] left_out_x, left_out_y, right_out_x, right_out_y;
	logic [8:0] touch_pos_x;
	logic [7:0] touch_pos_y;
	logic signed [9:0] touch_delta_x, drag_x;
	logic signed [8:0] touch_delta_y, drag_y;

	game_input_conditioner_unit u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state
	logic [7:0]  full_scale;
	logic [31:0] last_held;
	logic [8:0]  cur_x, org_x;
	logic [7:0]  cur_y, org_y;

	frame_t pending_frames[$];
	cond_t  expected_frames[$];
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  failed = 0;
	bit  done_sending = 0;
	bit  in_taken = 0;
	int  quiet_cycles = 0;

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] scale_axis(longint c, longint unsigned lq,
			longint unsigned fs);
		longint unsigned mag, q;
		mag = (c < 0) ? -c : c;
		if (lq >= 256 * fs) q = (mag << 22) / lq;
		else if (11 * lq > 256 * fs) q = (mag * 16384 * (11 * lq - 256 * fs)) / (10 * fs * lq);
		else q = 0;
		return (c < 0) ? -q : q;
	endfunction

	task automatic condition_stick(input logic signed [8:0] x, input logic signed [8:0] y,
			output logic signed [15:0] ox, output logic signed [15:0] oy);
		longint fx, fy;
		longint unsigned lq;
		fx = x;
		fy = -longint'(y);
		ox = '0;
		oy = '0;
		if (fx * fx + fy * fy != 0) begin
			lq = root64(longint'(fx * fx + fy * fy) << 16);
			ox = scale_axis(fx, lq, full_scale);
			oy = scale_axis(fy, lq, full_scale);
		end
	endtask

	task automatic predict_frame(input frame_t f);
		cond_t e;
		logic [8:0] lastx;
		logic [7:0] lasty;
		e.pressed  = f.held & ~last_held;
		e.released = last_held & ~f.held;
		condition_stick(f.lx, f.ly, e.lx, e.ly);
		condition_stick(f.rx, f.ry, e.rx, e.ry);
		lastx = cur_x;
		lasty = cur_y;
		if (f.held[TOUCH_BIT]) begin
			cur_x = f.tx;
			cur_y = f.ty;
		end
		if (e.pressed[TOUCH_BIT]) begin
			org_x = cur_x;
			org_y = cur_y;
			lastx = cur_x;
			lasty = cur_y;
		end
		last_held = f.held;
		e.px = cur_x;
		e.py = cur_y;
		e.dx = 10'({1'b0, cur_x} - {1'b0, lastx});
		e.dy = 9'({1'b0, cur_y} - {1'b0, lasty});
		e.gx = 10'({1'b0, cur_x} - {1'b0, org_x});
		e.gy = 9'({1'b0, cur_y} - {1'b0, org_y});
		expected_frames.push_back(e);
	endtask

	// Driver: a new beat goes out once the previous one was taken at the last rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					frame_t f;
					f = pending_frames.pop_front();
					in_valid <= 1'b1;
					buttons_held <= f.held;
					left_x <= f.lx;
					left_y <= f.ly;
					right_x <= f.rx;
					right_y <= f.ry;
					touch_in_x <= f.tx;
					touch_in_y <= f.ty;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Beats are predicted when accepted.
	always @(posedge clk) begin
		in_taken = in_valid && !in_stall;
		if (in_taken)
			predict_frame({buttons_held, left_x, left_y, right_x, right_y, touch_in_x, touch_in_y});
	end

	// Monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			cond_t got, e;
			got = {pressed_mask, released_mask, left_out_x, left_out_y, right_out_x, right_out_y,
				touch_pos_x, touch_pos_y, touch_delta_x, touch_delta_y, drag_x, drag_y};
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result beat, actual %h", $time, got);
				failed = 1;
			end else begin
				e = expected_frames.pop_front();
				if (got !== e) begin
					$display("%0t: mismatch expected %h actual %h", $time, e, got);
					$display("  sticks exp %0d %0d %0d %0d act %0d %0d %0d %0d", e.lx, e.ly,
						e.rx, e.ry, got.lx, got.ly, got.rx, got.ry);
					failed = 1;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted input, result or config beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic signed [8:0] rand_axis();
		case ($urandom_range(5))
			0: return -9'sd256;
			1: return 9'sd255;
			2: return 9'($urandom_range(20)) - 9'sd10;
			default: return 9'($urandom);
		endcase
	endfunction

	task automatic queue_frame(input logic [31:0] held, input logic signed [8:0] lx,
			input logic signed [8:0] ly, input logic signed [8:0] rx,
			input logic signed [8:0] ry, input logic [8:0] tx, input logic [7:0] ty);
		pending_frames.push_back({held, lx, ly, rx, ry, tx, ty});
	endtask

	function automatic logic last_touch_bit();
		if (pending_frames.size() == 0) return 1'b0;
		return pending_frames[pending_frames.size() - 1].held[TOUCH_BIT];
	endfunction

	task automatic queue_random(input int n);
		logic [31:0] h;
		repeat (n) begin
			h = $urandom;
			// Touch sequences: mostly toggle the flag slowly so holds and drags develop.
			h[TOUCH_BIT] = ($urandom_range(3) != 0) ? last_touch_bit() : 1'($urandom_range(1));
			queue_frame(h, rand_axis(), rand_axis(), rand_axis(), rand_axis(),
				($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(319)),
				($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(239)));
		end
	endtask

	task automatic drain_and_write(input logic [7:0] fs);
		wait (pending_frames.size() == 0 && !in_valid && expected_frames.size() == 0);
		repeat (50) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= fs;
		do @(posedge clk); while (!cfg_ready);
		full_scale = fs;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] tb;
		tb = 32'd1 << TOUCH_BIT;
		full_scale = gic_pkg::FS_RESET;
		last_held = '0;
		cur_x = '0;
		cur_y = '0;
		org_x = '0;
		org_y = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: stick extremes, zero vector, deadzone edge, touch press/hold/release.
		queue_frame('0, 0, 0, 0, 0, 0, 0);
		queue_frame('1, -256, -256, 255, 255, 319, 239);
		queue_frame('0, 255, -256, -256, 255, 0, 0);
		queue_frame(32'hAAAA_AAAA, 1, 0, 0, -1, 5, 5);
		queue_frame(32'h5555_5555, 14, 0, 0, 15, 10, 10);
		queue_frame(tb, 150, 0, 0, -150, 100, 50);
		queue_frame(tb, 106, 106, -106, -106, 319, 239);
		queue_frame(tb, 20, 0, 0, 20, 0, 0);
		queue_frame(tb | 32'h1, 0, 0, 0, 0, 511, 255);
		queue_frame('0, 0, 0, 0, 0, 7, 7);
		queue_frame(tb, 0, 0, 0, 0, 200, 100);
		queue_frame(tb, 0, 0, 0, 0, 0, 0);
		queue_frame(32'hFFFF_FFFF, 0, 0, 0, 0, 319, 239);
		queue_frame('0, 0, 0, 0, 0, 0, 0);
		drain_and_write(8'd0);
		queue_frame(tb, 1, 0, -256, 255, 3, 4);
		queue_random(20);
		drain_and_write(8'd1);
		queue_random(20);
		drain_and_write(8'd255);
		queue_random(40);

		// Random phases with different idling.
		drain_and_write(8'($urandom_range(1, 255)));
		queue_random(100);
		drain_and_write(8'd150);
		send_idle_pct = 77;
		queue_random(80);
		drain_and_write(8'($urandom_range(20, 200)));
		send_idle_pct = 0;
		stall_pct = 77;
		queue_random(80);
		drain_and_write(8'd100);
		send_idle_pct = 11;
		stall_pct = 11;
		queue_random(90);

		wait (pending_frames.size() == 0 && !in_valid && expected_frames.size() == 0);
		repeat (60) @(posedge clk);
		if (!failed) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
